[rtl/fpsmv_pkg.sv]
// ----------------------------------------------------------------------------
// fpsmv_pkg
// shared widths, codes and payload types of the five-point stencil unit
// ----------------------------------------------------------------------------
`default_nettype none

package fpsmv_pkg;

  localparam int MAX_WIDTH = 256;
  localparam int FRAC_BITS = 16;

  localparam int DATA_W    = 32;
  localparam int GW_BITS   = 9;
  localparam int TERMS     = 5;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + $clog2(TERMS) + 1;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int WID_BITS  = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH     = 2 * MAX_WIDTH;
  localparam int ADDR_BITS = $clog2(DEPTH);

  localparam int CFG_IDX_BITS = 2;

  localparam logic [DATA_W-1:0]  COEF_ONE         = DATA_W'(1) << FRAC_BITS;
  localparam logic [GW_BITS-1:0] GRID_WIDTH_RESET = GW_BITS'(16);

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COEF_CENTER     = 2'd0,
    REG_COEF_HORIZONTAL = 2'd1,
    REG_COEF_VERTICAL   = 2'd2,
    REG_GRID_WIDTH      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] sample;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     saturated;
    logic                     last;
  } rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] coef;
    logic [DATA_W-1:0] opnd;
  } term_t;

  typedef struct packed {
    logic                    last;
    logic [ACC_W-1:0]        sum;
    term_t [TERMS-1:0]       terms;
  } flow_t;

endpackage

`default_nettype wire

[rtl/fpsmv_ram.sv]
// ----------------------------------------------------------------------------
// fpsmv_ram
// generic ram, one write port and two registered read ports, read-first
// ----------------------------------------------------------------------------
`default_nettype none

module fpsmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/fpsmv_cell.sv]
// ----------------------------------------------------------------------------
// fpsmv_cell
// one multiply-accumulate cell of the term chain: takes the head term,
// multiplies it, adds it to the running sum and passes the rest on
// ----------------------------------------------------------------------------
`default_nettype none

module fpsmv_cell import fpsmv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  flow_t up_flow,
  output logic  dn_valid,
  input  logic  dn_ready,
  output flow_t dn_flow
);

  logic                     va;
  flow_t                    flow_a;
  logic signed [PROD_W-1:0] prod;
  logic                     en_a;
  logic                     en_b;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  sum_a;
  logic signed [ACC_W-1:0]  sum_next;
  flow_t                    shift_next;
  flow_t                    dn_flow_next;

  assign en_b     = !dn_valid || dn_ready;
  assign en_a     = !va || en_b;
  assign up_ready = en_a;

  assign mul_a = up_flow.terms[0].coef;
  assign mul_b = up_flow.terms[0].opnd;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    shift_next = up_flow;
    for (int i = 0; i < TERMS - 1; i++) begin
      shift_next.terms[i] = up_flow.terms[i+1];
    end
    shift_next.terms[TERMS-1] = '0;
  end

  assign sum_a    = flow_a.sum;
  assign sum_next = sum_a + ACC_W'(prod);

  always_comb begin
    dn_flow_next     = flow_a;
    dn_flow_next.sum = sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (en_a) begin
        va <= up_valid;
      end
      if (en_b) begin
        dn_valid <= va;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && up_valid) begin
      prod   <= mul_p;
      flow_a <= shift_next;
    end
    if (en_b && va) begin
      dn_flow <= dn_flow_next;
    end
  end

endmodule

`default_nettype wire

[rtl/five_point_stencil_matvec_unit.sv]
// ----------------------------------------------------------------------------
// five_point_stencil_matvec_unit
// five-point stencil matrix-vector product on a raster stream of grid values
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_stall   | req_data  (command, sample)
//  rsp     | out       | rsp_valid / rsp_stall   | rsp_data  (result, saturated, last)
//  cfg     | in        | cfg_write               | cfg_index, cfg_data
//
//  one request per cycle while req_stall is low; a result passes the delay-line
//  read register, two registers in each of the five mac cells and one output
//  register. the two-row delay line is a pair of 512-word rams written in
//  parallel, giving four reads per request. reset needs no clearing pass.
//  stages hold on rsp_stall and empty stages fill, so req_stall rises only
//  when the whole pipe is full.
// ----------------------------------------------------------------------------
`default_nettype none

module five_point_stencil_matvec_unit import fpsmv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  req_t                    req_data,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output rsp_t                    rsp_data,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DATA_W-1:0]       cfg_data
);

  // configuration
  logic [DATA_W-1:0]  coef_center;
  logic [DATA_W-1:0]  coef_horizontal;
  logic [DATA_W-1:0]  coef_vertical;
  logic [GW_BITS-1:0] grid_width;

  // sequencing state
  logic [COL_BITS-1:0] input_column;
  logic [1:0]          rows_seen;
  logic [COL_BITS-1:0] drain_column;

  logic [WID_BITS-1:0]  w;
  logic [COL_BITS-1:0]  c;
  logic [COL_BITS-1:0]  d;
  logic [COL_BITS-1:0]  p;
  logic [ADDR_BITS-1:0] cur_base;
  logic [ADDR_BITS-1:0] prev_base;
  logic                 is_push;
  logic                 push_blocked;
  logic                 drain_ok;
  logic                 row_end;
  logic                 fin;
  logic                 emit;
  logic                 accept;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [ADDR_BITS-1:0] addr_mid;
  logic [ADDR_BITS-1:0] addr_left;
  logic [ADDR_BITS-1:0] addr_right;
  logic [ADDR_BITS-1:0] addr_up;

  // read stage
  logic                en1;
  logic                v1;
  logic                left1;
  logic                right1;
  logic                up1;
  logic                down1;
  logic                last1;
  logic [DATA_W-1:0]   u1;
  logic [DATA_W-1:0]   rd_mid;
  logic [DATA_W-1:0]   rd_left;
  logic [DATA_W-1:0]   rd_right;
  logic [DATA_W-1:0]   rd_up;
  flow_t               flow1;

  // cell chain
  logic                chain_valid [TERMS+1];
  logic                chain_ready [TERMS+1];
  flow_t               chain_flow  [TERMS+1];

  // output stage
  logic                    en_o;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;
  logic                    fits;
  rsp_t                    rsp_next;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_center     <= COEF_ONE;
      coef_horizontal <= '0;
      coef_vertical   <= '0;
      grid_width      <= GRID_WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_CENTER:     coef_center     <= cfg_data;
        REG_COEF_HORIZONTAL: coef_horizontal <= cfg_data;
        REG_COEF_VERTICAL:   coef_vertical   <= cfg_data;
        REG_GRID_WIDTH:      grid_width      <= cfg_data[GW_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective width and columns
  always_comb begin
    if (grid_width == '0) begin
      w = WID_BITS'(1);
    end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
      w = WID_BITS'(MAX_WIDTH);
    end else begin
      w = WID_BITS'(grid_width);
    end
  end

  assign c = (WID_BITS'(input_column) < w) ? input_column : COL_BITS'(w - WID_BITS'(1));
  assign d = (WID_BITS'(drain_column) < w) ? drain_column : COL_BITS'(w - WID_BITS'(1));

  assign cur_base  = rows_seen[0] ? ADDR_BITS'(w) : '0;
  assign prev_base = rows_seen[0] ? '0 : ADDR_BITS'(w);

  assign is_push      = (req_data.command == CMD_PUSH);
  assign push_blocked = (drain_column != '0);
  assign drain_ok     = (rows_seen != 2'd0) && (input_column == '0);
  assign row_end      = (WID_BITS'(c) + WID_BITS'(1)) >= w;
  assign fin          = (WID_BITS'(d) + WID_BITS'(1)) >= w;
  assign p            = is_push ? c : d;
  assign emit         = is_push ? (!push_blocked && (rows_seen != 2'd0)) : drain_ok;

  assign accept  = req_valid && !req_stall;
  assign wr_en   = accept && is_push && !push_blocked;
  assign wr_addr = cur_base + ADDR_BITS'(c);

  assign addr_mid   = prev_base + ADDR_BITS'(p);
  assign addr_left  = prev_base + ADDR_BITS'(p) - ADDR_BITS'(1);
  assign addr_right = prev_base + ADDR_BITS'(p) + ADDR_BITS'(1);
  assign addr_up    = cur_base + ADDR_BITS'(p);

  always_ff @(posedge clk) begin
    if (rst) begin
      input_column <= '0;
      rows_seen    <= 2'd0;
      drain_column <= '0;
    end else if (accept) begin
      if (is_push) begin
        if (!push_blocked) begin
          if (row_end) begin
            input_column <= '0;
            rows_seen    <= (rows_seen == 2'd3) ? 2'd2 : rows_seen + 2'd1;
          end else begin
            input_column <= c + COL_BITS'(1);
          end
        end
      end else if (drain_ok) begin
        if (fin) begin
          drain_column <= '0;
          input_column <= '0;
          rows_seen    <= 2'd0;
        end else begin
          drain_column <= d + COL_BITS'(1);
        end
      end
    end
  end

  // two-row delay line, two copies for four reads
  fpsmv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_line_a (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (req_data.sample),
    .re     (en1),
    .raddr0 (addr_mid),
    .raddr1 (addr_left),
    .rdata0 (rd_mid),
    .rdata1 (rd_left)
  );

  fpsmv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_line_b (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (req_data.sample),
    .re     (en1),
    .raddr0 (addr_right),
    .raddr1 (addr_up),
    .rdata0 (rd_right),
    .rdata1 (rd_up)
  );

  // read stage
  assign en1       = !v1 || chain_ready[0];
  assign req_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      left1  <= (p != '0);
      right1 <= (WID_BITS'(p) + WID_BITS'(1)) < w;
      up1    <= rows_seen[1];
      down1  <= is_push;
      last1  <= !is_push && fin;
      u1     <= req_data.sample;
    end
  end

  always_comb begin
    flow1                = '0;
    flow1.last           = last1;
    flow1.terms[0].coef  = coef_center;
    flow1.terms[0].opnd  = rd_mid;
    flow1.terms[1].coef  = coef_horizontal;
    flow1.terms[1].opnd  = left1 ? rd_left : '0;
    flow1.terms[2].coef  = coef_horizontal;
    flow1.terms[2].opnd  = right1 ? rd_right : '0;
    flow1.terms[3].coef  = coef_vertical;
    flow1.terms[3].opnd  = up1 ? rd_up : '0;
    flow1.terms[4].coef  = coef_vertical;
    flow1.terms[4].opnd  = down1 ? u1 : '0;
  end

  assign chain_valid[0] = v1;
  assign chain_flow[0]  = flow1;

  // mac chain
  for (genvar k = 0; k < TERMS; k++) begin : g_cell
    fpsmv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[k]),
      .up_ready (chain_ready[k]),
      .up_flow  (chain_flow[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_ready (chain_ready[k+1]),
      .dn_flow  (chain_flow[k+1])
    );
  end

  // scale, clamp and register
  assign en_o               = !rsp_valid || !rsp_stall;
  assign chain_ready[TERMS] = en_o;

  assign acc     = chain_flow[TERMS].sum;
  assign shifted = acc >>> FRAC_BITS;
  assign fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);

  always_comb begin
    rsp_next.saturated = !fits;
    rsp_next.last      = chain_flow[TERMS].last;
    if (fits) begin
      rsp_next.result = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      rsp_next.result = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      rsp_next.result = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en_o) begin
      rsp_valid <= chain_valid[TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && chain_valid[TERMS]) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

`default_nettype wire
